// File: rtl/assert_macros.svh
// Assertion macros shared by the effective address unit RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/m68kea_pkg.sv
// Shared types, mode codes and helper functions for the effective address unit.
// No dependencies; the interfaces, the RTL modules and the bench import this package.
package m68kea_pkg;

    // Addressing mode field codes
    localparam logic [2:0] MODE_DN_DIRECT = 3'd0;
    localparam logic [2:0] MODE_AN_DIRECT = 3'd1;
    localparam logic [2:0] MODE_AN_IND    = 3'd2;
    localparam logic [2:0] MODE_AN_POST   = 3'd3;
    localparam logic [2:0] MODE_AN_PRE    = 3'd4;
    localparam logic [2:0] MODE_AN_DISP   = 3'd5;
    localparam logic [2:0] MODE_AN_INDEX  = 3'd6;
    localparam logic [2:0] MODE_SPECIAL   = 3'd7;

    // Register field codes under the special mode
    localparam logic [2:0] SPC_ABS_SHORT = 3'd0;
    localparam logic [2:0] SPC_ABS_LONG  = 3'd1;
    localparam logic [2:0] SPC_PC_DISP   = 3'd2;
    localparam logic [2:0] SPC_PC_INDEX  = 3'd3;
    localparam logic [2:0] SPC_IMMEDIATE = 3'd4;
    // Highest of the reserved register codes
    localparam logic [2:0] SPC_RESERVED  = 3'd7;

    // Stack pointer register number and the byte and word size codes
    localparam logic [2:0] REG_SP     = 3'd7;
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;

    // Displacement size codes of the full extension format
    localparam logic [1:0] DSZ_RESERVED = 2'd0;
    localparam logic [1:0] DSZ_NULL     = 2'd1;
    localparam logic [1:0] DSZ_WORD     = 2'd2;
    localparam logic [1:0] DSZ_LONG     = 2'd3;

    localparam int EXT_WORDS = 5;

    typedef struct packed {
        logic        kind;
        logic [2:0]  mode;
        logic [2:0]  reg_req;
        logic [2:0]  size;
        logic        is_write;
        logic [31:0] an_value;
        logic [31:0] index_value;
        logic [31:0] pc_value;
        logic [15:0] first_word;
        logic [63:0] next_words;
        logic [31:0] mem_data;
    } ea_req_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] an_new;
        logic        an_write;
        logic        indirect_pending;
        logic [2:0]  words_used;
        logic        illegal;
    } ea_rsp_t;

    typedef struct packed {
        logic        pending_valid;
        logic [31:0] pending_addend;
    } ea_state_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

// File: rtl/m68kea_req_if.sv
// Request channel of the effective address unit: valid/ready plus request fields.
// Depends on m68kea_pkg.
interface m68kea_req_if import m68kea_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [2:0]  size;
    logic        is_write;
    logic [31:0] an_value;
    logic [31:0] index_value;
    logic [31:0] pc_value;
    logic [15:0] first_word;
    logic [63:0] next_words;
    logic [31:0] mem_data;

    modport source (
        output valid, kind, mode, reg_req, size, is_write, an_value, index_value,
               pc_value, first_word, next_words, mem_data,
        input  ready
    );

    modport sink (
        input  valid, kind, mode, reg_req, size, is_write, an_value, index_value,
               pc_value, first_word, next_words, mem_data,
        output ready
    );
endinterface

// File: rtl/m68kea_rsp_if.sv
// Result channel of the effective address unit: valid/ready plus result fields.
// Depends on m68kea_pkg.
interface m68kea_rsp_if import m68kea_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic [31:0] an_new;
    logic        an_write;
    logic        indirect_pending;
    logic [2:0]  words_used;
    logic        illegal;

    modport source (
        output valid, address, an_new, an_write, indirect_pending, words_used, illegal,
        input  ready
    );

    modport sink (
        input  valid, address, an_new, an_write, indirect_pending, words_used, illegal,
        output ready
    );
endinterface

// File: rtl/m68k_effective_address_unit.sv
// 68020 effective address unit: takes one request per cycle while the result side is
// ready and returns one result for each through the input and result registers.
// Depends on m68kea_pkg, m68kea_req_if, m68kea_rsp_if, m68kea_calc and assert_macros.svh.
//
// Throughput is one request per cycle whenever the result side is ready; the input
// register and the result register lie around the single pass of address logic. A
// memory-indirect request answers with the pointer fetch address and indirect_pending
// set; the next request with kind = 1 carries the pointer read and receives the final
// address. The pending indirection is updated as each request moves into the result
// register, so a kind = 1 request may directly follow the request that opened the
// indirection. Any kind = 0 request drops an open indirection.
`include "assert_macros.svh"

module m68k_effective_address_unit import m68kea_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    m68kea_req_if.sink    req,
    m68kea_rsp_if.source  rsp
);

    logic      s0_valid_reg;
    ea_req_t   s0_data_reg;
    logic      out_valid_reg;
    ea_rsp_t   out_data_reg;
    ea_state_t state_reg;
    ea_state_t state_next;
    ea_rsp_t   calc_rsp;
    ea_req_t   req_data;
    logic      s1_load;
    logic      s0_load;

    // Gather request fields
    assign req_data.kind        = req.kind;
    assign req_data.mode        = req.mode;
    assign req_data.reg_req     = req.reg_req;
    assign req_data.size        = req.size;
    assign req_data.is_write    = req.is_write;
    assign req_data.an_value    = req.an_value;
    assign req_data.index_value = req.index_value;
    assign req_data.pc_value    = req.pc_value;
    assign req_data.first_word  = req.first_word;
    assign req_data.next_words  = req.next_words;
    assign req_data.mem_data    = req.mem_data;

    // Advance when the result register is free or being drained
    assign s1_load   = s0_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s0_valid_reg || s1_load;
    assign s0_load   = req.valid && req.ready;

    m68kea_calc u_calc (
        .req        (s0_data_reg),
        .state      (state_reg),
        .rsp        (calc_rsp),
        .state_next (state_next)
    );

    // Hold valid flags and pending indirection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s0_valid_reg <= req.valid;
            end
            if (s1_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            s0_data_reg <= req_data;
        end
        if (s1_load)
        begin
            out_data_reg <= calc_rsp;
        end
    end

    // Drive result channel
    assign rsp.valid            = out_valid_reg;
    assign rsp.address          = out_data_reg.address;
    assign rsp.an_new           = out_data_reg.an_new;
    assign rsp.an_write         = out_data_reg.an_write;
    assign rsp.indirect_pending = out_data_reg.indirect_pending;
    assign rsp.words_used       = out_data_reg.words_used;
    assign rsp.illegal          = out_data_reg.illegal;

    `ASSERT_IMPLIES(a_illegal_clean, out_valid_reg && out_data_reg.illegal,
        out_data_reg.address == 32'd0 && out_data_reg.an_new == 32'd0 &&
        !out_data_reg.an_write && !out_data_reg.indirect_pending &&
        out_data_reg.words_used == 3'd0, "illegal result carries nonzero fields")
    `ASSERT_ALWAYS(a_addend_idle, state_reg.pending_valid || state_reg.pending_addend == 32'd0,
        "pending addend nonzero with no indirection open")
    `ASSERT_IMPLIES(a_writeback_plain, out_valid_reg && out_data_reg.an_write,
        !out_data_reg.indirect_pending && out_data_reg.words_used == 3'd0,
        "register write-back combined with extension words or indirection")
    `ASSERT_NEXT(a_s0_hold, s0_valid_reg && !s1_load, s0_valid_reg,
        "stalled request dropped from input register")
    `ASSERT_NEXT(a_pending_src, s1_load && calc_rsp.indirect_pending,
        state_reg.pending_valid && out_data_reg.indirect_pending,
        "indirection result without pending state")

endmodule

// File: rtl/m68kea_calc.sv
// Combinational effective address computation for one registered request.
// Depends on m68kea_pkg; also produces the next pending-indirection state.
module m68kea_calc import m68kea_pkg::*;
(
    input  ea_req_t   req,
    input  ea_state_t state,
    output ea_rsp_t   rsp,
    output ea_state_t state_next
);

    logic [15:0] ext_w [EXT_WORDS];
    logic [15:0] fw;
    logic [31:0] ix;
    logic [31:0] scaled;
    logic [31:0] base;
    logic        full_bs;
    logic        full_is;
    logic [1:0]  bdc;
    logic        post;
    logic [1:0]  odc;
    logic [31:0] bd;
    logic [2:0]  od_k;
    logic [2:0]  od_k1;
    logic [31:0] od;
    logic [2:0]  idx_words;
    logic [31:0] base2;
    logic        idx_ok;
    logic        idx_ind;
    logic [31:0] idx_addr;
    logic [31:0] idx_addend;
    logic [2:0]  size_eff;
    logic        ok;
    logic        ind;
    logic [31:0] addr;
    logic [31:0] an_new;
    logic        anw;
    logic [2:0]  words;

    // Split the extension stream into words, first word at index zero
    assign fw       = req.first_word;
    assign ext_w[0] = fw;
    assign ext_w[1] = req.next_words[63:48];
    assign ext_w[2] = req.next_words[47:32];
    assign ext_w[3] = req.next_words[31:16];
    assign ext_w[4] = req.next_words[15:0];

    // Index register: word or long, then scale
    assign ix     = fw[11] ? req.index_value : sext16(req.index_value[15:0]);
    assign scaled = ix << fw[10:9];
    assign base   = (req.mode == MODE_AN_INDEX) ? req.an_value : req.pc_value;

    // Full format control fields
    assign full_bs = fw[7];
    assign full_is = fw[6];
    assign bdc     = fw[5:4];
    assign post    = fw[2];
    assign odc     = fw[1:0];

    // Base displacement and position of the outer displacement
    always_comb
    begin
        case (bdc)
            DSZ_WORD:
            begin
                bd   = sext16(ext_w[1]);
                od_k = 3'd2;
            end
            DSZ_LONG:
            begin
                bd   = {ext_w[1], ext_w[2]};
                od_k = 3'd3;
            end
            default:
            begin
                bd   = '0;
                od_k = 3'd1;
            end
        endcase
    end

    assign od_k1 = od_k + 3'd1;

    // Outer displacement and total extension word count
    always_comb
    begin
        case (odc)
            DSZ_WORD:
            begin
                od        = sext16(ext_w[od_k]);
                idx_words = od_k + 3'd1;
            end
            DSZ_LONG:
            begin
                od        = {ext_w[od_k], ext_w[od_k1]};
                idx_words = od_k + 3'd2;
            end
            default:
            begin
                od        = '0;
                idx_words = od_k;
            end
        endcase
    end

    assign base2 = (full_bs ? 32'd0 : base) + bd;

    // Indexed modes: brief format, full format without and with indirection
    always_comb
    begin
        idx_ok     = 1'b1;
        idx_ind    = 1'b0;
        idx_addr   = '0;
        idx_addend = '0;
        if (!fw[8])
        begin
            idx_addr = base + sext8(fw[7:0]) + scaled;
        end
        else if (fw[3] || bdc == DSZ_RESERVED || (odc == DSZ_RESERVED && post)
                 || (full_is && post))
        begin
            idx_ok = 1'b0;
        end
        else if (odc == DSZ_RESERVED)
        begin
            idx_addr = full_is ? base2 : base2 + scaled;
        end
        else
        begin
            idx_ind = 1'b1;
            if (full_is || post)
            begin
                idx_addr   = base2;
                idx_addend = post ? od + scaled : od;
            end
            else
            begin
                idx_addr   = base2 + scaled;
                idx_addend = od;
            end
        end
    end

    // Byte steps through the stack pointer keep it word aligned
    assign size_eff = (req.reg_req == REG_SP && req.size == SIZE_BYTE) ? SIZE_WORD : req.size;

    // Mode decode and result assembly
    always_comb
    begin
        ok         = 1'b1;
        ind        = 1'b0;
        addr       = '0;
        an_new     = '0;
        anw        = 1'b0;
        words      = '0;
        rsp        = '0;
        state_next = '0;
        if (req.kind)
        begin
            // Pointer data: finish a pending indirection
            if (!state.pending_valid)
            begin
                rsp.illegal = 1'b1;
                state_next  = state;
            end
            else
            begin
                rsp.address = req.mem_data + state.pending_addend;
            end
        end
        else
        begin
            case (req.mode)
                MODE_AN_IND:
                begin
                    addr = req.an_value;
                end
                MODE_AN_POST:
                begin
                    ok     = (size_eff != 3'd0);
                    addr   = req.an_value;
                    an_new = req.an_value + {29'd0, size_eff};
                    anw    = 1'b1;
                end
                MODE_AN_PRE:
                begin
                    ok     = (size_eff != 3'd0);
                    an_new = req.an_value - {29'd0, size_eff};
                    addr   = an_new;
                    anw    = 1'b1;
                end
                MODE_AN_DISP:
                begin
                    addr  = req.an_value + sext16(fw);
                    words = 3'd1;
                end
                MODE_AN_INDEX:
                begin
                    ok    = idx_ok;
                    ind   = idx_ind;
                    addr  = idx_addr;
                    words = fw[8] ? idx_words : 3'd1;
                end
                MODE_SPECIAL:
                begin
                    case (req.reg_req)
                        SPC_ABS_SHORT:
                        begin
                            addr  = sext16(fw);
                            words = 3'd1;
                        end
                        SPC_ABS_LONG:
                        begin
                            addr  = {fw, ext_w[1]};
                            words = 3'd2;
                        end
                        SPC_PC_DISP:
                        begin
                            ok    = !req.is_write;
                            addr  = req.pc_value + sext16(fw);
                            words = 3'd1;
                        end
                        SPC_PC_INDEX:
                        begin
                            ok    = !req.is_write && idx_ok;
                            ind   = idx_ind;
                            addr  = idx_addr;
                            words = fw[8] ? idx_words : 3'd1;
                        end
                        default:
                        begin
                            ok = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase

            if (!ok)
            begin
                rsp.illegal = 1'b1;
            end
            else
            begin
                rsp.address          = addr;
                rsp.an_new           = an_new;
                rsp.an_write         = anw;
                rsp.indirect_pending = ind;
                rsp.words_used       = words;
                state_next.pending_valid  = ind;
                state_next.pending_addend = ind ? idx_addend : 32'd0;
            end
        end
    end

endmodule

// File: tb/testbench.sv
// Self-checking bench for m68k_effective_address_unit: directed and random address requests,
// a scoreboard predicted in-bench, and random idling on both channels.
// Depends on m68kea_pkg, m68kea_req_if, m68kea_rsp_if and the unit RTL.
module testbench import m68kea_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    m68kea_req_if req_ch ();
    m68kea_rsp_if rsp_ch ();

    m68k_effective_address_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Request side drive registers, known from time zero
    ea_req_t req_drv = '0;
    logic    req_vld = 1'b0;
    logic    rsp_rdy = 1'b0;
    logic    hold_off = 1'b0;

    assign req_ch.valid       = req_vld;
    assign req_ch.kind        = req_drv.kind;
    assign req_ch.mode        = req_drv.mode;
    assign req_ch.reg_req     = req_drv.reg_req;
    assign req_ch.size        = req_drv.size;
    assign req_ch.is_write    = req_drv.is_write;
    assign req_ch.an_value    = req_drv.an_value;
    assign req_ch.index_value = req_drv.index_value;
    assign req_ch.pc_value    = req_drv.pc_value;
    assign req_ch.first_word  = req_drv.first_word;
    assign req_ch.next_words  = req_drv.next_words;
    assign req_ch.mem_data    = req_drv.mem_data;
    assign rsp_ch.ready       = rsp_rdy;

    ea_req_t request_q[$];
    ea_rsp_t address_q[$];

    // Predicted pointer indirection state
    logic        ptr_open = 1'b0;
    logic [31:0] ptr_addend = '0;

    int unsigned cycle_count = 0;
    int unsigned req_gap = 0;
    int unsigned rsp_stall = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_illegal = 0;
    int          n_pointer = 0;
    int          n_update = 0;
    int          n_errors = 0;

    // Periodic calm windows in which no new idle gaps are picked on either side
    wire quiet = (cycle_count[8:7] == 2'b00);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] widen16(input logic [15:0] v);
        logic signed [31:0] s;
        s = signed'(v);
        return s;
    endfunction

    function automatic logic [31:0] widen8(input logic [7:0] v);
        logic signed [31:0] s;
        s = signed'(v);
        return s;
    endfunction

    // Extension word k: 0 is the first word, 1..4 come from the following words
    function automatic logic [15:0] ext_at(input ea_req_t r, input int k);
        if (k == 0)
            return r.first_word;
        if (k > 4)
            return 16'h0000;
        return r.next_words[63 - 16 * (k - 1) -: 16];
    endfunction

    // Brief and full index formats; returns 0 on a reserved encoding
    function automatic logic indexed_address(input ea_req_t r, input logic [31:0] base,
                                             output logic [31:0] addr,
                                             output logic [2:0] words,
                                             output logic ind, output logic [31:0] addend);
        logic [15:0] fw;
        logic [31:0] ix;
        logic [31:0] scaled;
        logic [31:0] bd;
        logic [31:0] od;
        logic        base_sup;
        logic        idx_sup;
        logic        post;
        logic [1:0]  bdc;
        logic [1:0]  odc;
        int          k;
        fw = r.first_word;
        ix = fw[11] ? r.index_value : widen16(r.index_value[15:0]);
        scaled = ix << fw[10:9];
        k = 1;
        bd = '0;
        od = '0;
        addr = '0;
        words = '0;
        ind = 1'b0;
        addend = '0;
        if (!fw[8])
        begin
            addr = base + widen8(fw[7:0]) + scaled;
            words = 3'd1;
            return 1'b1;
        end
        if (fw[3])
            return 1'b0;
        base_sup = fw[7];
        idx_sup = fw[6];
        bdc = fw[5:4];
        post = fw[2];
        odc = fw[1:0];
        if (bdc == DSZ_RESERVED)
            return 1'b0;
        if (odc == DSZ_RESERVED && post)
            return 1'b0;
        if (idx_sup && post)
            return 1'b0;
        if (bdc == DSZ_WORD)
        begin
            bd = widen16(ext_at(r, k));
            k += 1;
        end
        else if (bdc == DSZ_LONG)
        begin
            bd = {ext_at(r, k), ext_at(r, k + 1)};
            k += 2;
        end
        if (base_sup)
            base = '0;
        base = base + bd;
        if (odc == DSZ_RESERVED)
        begin
            addr = idx_sup ? base : base + scaled;
            words = 3'(k);
            return 1'b1;
        end
        if (odc == DSZ_WORD)
        begin
            od = widen16(ext_at(r, k));
            k += 1;
        end
        else if (odc == DSZ_LONG)
        begin
            od = {ext_at(r, k), ext_at(r, k + 1)};
            k += 2;
        end
        if (idx_sup || post)
        begin
            addr = base;
            addend = post ? od + scaled : od;
        end
        else
        begin
            addr = base + scaled;
            addend = od;
        end
        ind = 1'b1;
        words = 3'(k);
        return 1'b1;
    endfunction

    // Compute the expected result of one accepted request and advance the pointer state
    function automatic ea_rsp_t predict_ea(input ea_req_t r);
        ea_rsp_t     o;
        logic [2:0]  step;
        logic        ok;
        logic        ind;
        logic [31:0] addr;
        logic [31:0] addend;
        logic [2:0]  words;
        o = '0;
        ok = 1'b1;
        ind = 1'b0;
        addr = '0;
        addend = '0;
        words = '0;
        if (r.kind)
        begin
            if (!ptr_open)
            begin
                o.illegal = 1'b1;
                return o;
            end
            o.address = r.mem_data + ptr_addend;
            ptr_open = 1'b0;
            ptr_addend = '0;
            return o;
        end
        ptr_open = 1'b0;
        ptr_addend = '0;
        step = (r.reg_req == REG_SP && r.size == SIZE_BYTE) ? SIZE_WORD : r.size;
        case (r.mode)
            MODE_AN_IND:
                o.address = r.an_value;
            MODE_AN_POST:
                if (step == '0)
                    ok = 1'b0;
                else
                begin
                    o.address = r.an_value;
                    o.an_new = r.an_value + step;
                    o.an_write = 1'b1;
                end
            MODE_AN_PRE:
                if (step == '0)
                    ok = 1'b0;
                else
                begin
                    o.an_new = r.an_value - step;
                    o.address = o.an_new;
                    o.an_write = 1'b1;
                end
            MODE_AN_DISP:
            begin
                o.address = r.an_value + widen16(r.first_word);
                o.words_used = 3'd1;
            end
            MODE_AN_INDEX:
            begin
                ok = indexed_address(r, r.an_value, addr, words, ind, addend);
                o.address = addr;
                o.words_used = words;
            end
            MODE_SPECIAL:
                case (r.reg_req)
                    SPC_ABS_SHORT:
                    begin
                        o.address = widen16(r.first_word);
                        o.words_used = 3'd1;
                    end
                    SPC_ABS_LONG:
                    begin
                        o.address = {r.first_word, ext_at(r, 1)};
                        o.words_used = 3'd2;
                    end
                    SPC_PC_DISP:
                        if (r.is_write)
                            ok = 1'b0;
                        else
                        begin
                            o.address = r.pc_value + widen16(r.first_word);
                            o.words_used = 3'd1;
                        end
                    SPC_PC_INDEX:
                        if (r.is_write)
                            ok = 1'b0;
                        else
                        begin
                            ok = indexed_address(r, r.pc_value, addr, words, ind, addend);
                            o.address = addr;
                            o.words_used = words;
                        end
                    default:
                        ok = 1'b0;
                endcase
            default:
                ok = 1'b0;
        endcase
        if (!ok)
        begin
            o = '0;
            o.illegal = 1'b1;
            return o;
        end
        ptr_open = ind;
        ptr_addend = ind ? addend : '0;
        o.indirect_pending = ind;
        return o;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || hold_off || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic ea_req_t random_fields();
        ea_req_t r;
        r.kind        = 1'($urandom_range(0, 1));
        r.mode        = 3'($urandom_range(0, 7));
        r.reg_req     = 3'($urandom_range(0, 7));
        r.size        = 3'($urandom_range(0, 7));
        r.is_write    = 1'($urandom_range(0, 1));
        r.an_value    = $urandom;
        r.index_value = $urandom;
        r.pc_value    = $urandom;
        r.first_word  = 16'($urandom);
        r.next_words  = {$urandom, $urandom};
        r.mem_data    = $urandom;
        return r;
    endfunction

    function automatic ea_req_t pointer_data();
        ea_req_t r;
        r = random_fields();
        r.kind = 1'b1;
        return r;
    endfunction

    function automatic ea_req_t addr_req(input logic [2:0] mode, input logic [2:0] rsel,
                                         input logic [2:0] size, input logic wr,
                                         input logic [31:0] an, input logic [15:0] fw);
        ea_req_t r;
        r = random_fields();
        r.kind = 1'b0;
        r.mode = mode;
        r.reg_req = rsel;
        r.size = size;
        r.is_write = wr;
        r.an_value = an;
        r.first_word = fw;
        return r;
    endfunction

    // Index extension word: brief, well-formed full, or raw
    function automatic logic [15:0] index_word();
        logic [15:0] fw;
        int unsigned pick;
        fw = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            fw[8] = 1'b0;
        else if (pick < 85)
        begin
            fw[8] = 1'b1;
            fw[3] = 1'b0;
            fw[5:4] = 2'($urandom_range(DSZ_NULL, DSZ_LONG));
            if (fw[1:0] == DSZ_RESERVED || fw[6])
                fw[2] = 1'b0;
        end
        return fw;
    endfunction

    function automatic ea_req_t random_request();
        ea_req_t     r;
        int unsigned pick;
        r = random_fields();
        r.kind = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.mode = 3'($urandom_range(MODE_DN_DIRECT, MODE_AN_DIRECT));
        else if (pick < 30)
            r.mode = 3'($urandom_range(MODE_AN_IND, MODE_AN_DISP));
        else if (pick < 65)
            r.mode = MODE_AN_INDEX;
        else
        begin
            r.mode = MODE_SPECIAL;
            r.reg_req = ($urandom_range(0, 9) < 8)
                        ? 3'($urandom_range(SPC_ABS_SHORT, SPC_PC_INDEX))
                        : 3'($urandom_range(SPC_IMMEDIATE, SPC_RESERVED));
            r.is_write = ($urandom_range(0, 5) == 0);
        end
        if ($urandom_range(0, 9) < 8)
            r.size = 3'($urandom_range(0, 4));
        if (r.mode == MODE_AN_INDEX || (r.mode == MODE_SPECIAL && r.reg_req == SPC_PC_INDEX))
            r.first_word = index_word();
        return r;
    endfunction

    function automatic logic opens_pointer(input ea_req_t r);
        return (r.mode == MODE_AN_INDEX || (r.mode == MODE_SPECIAL && r.reg_req == SPC_PC_INDEX))
               && r.first_word[8] && r.first_word[1:0] != DSZ_RESERVED;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        $display("%0t: mismatch on %s: expected %h, got %h", $time, field, exp_v, got_v);
        n_errors++;
    endtask

    // Driver: present queued requests with random gaps, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld <= 1'b0;
            req_gap <= 0;
        end
        else
        begin
            if (req_vld && req_ch.ready)
            begin
                address_q.push_back(predict_ea(req_drv));
                n_accepted <= n_accepted + 1;
            end
            if (!req_vld || req_ch.ready)
            begin
                if (req_gap != 0)
                begin
                    req_vld <= 1'b0;
                    req_gap <= req_gap - 1;
                end
                else if (request_q.size() != 0)
                begin
                    req_drv <= request_q.pop_front();
                    req_vld <= 1'b1;
                    req_gap <= pick_gap();
                end
                else
                    req_vld <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expected result
    always @(posedge clk or negedge rst_n)
    begin
        ea_rsp_t got;
        ea_rsp_t exp_r;
        if (!rst_n)
        begin
            rsp_rdy <= 1'b0;
            rsp_stall <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_rdy)
            begin
                got.address = rsp_ch.address;
                got.an_new = rsp_ch.an_new;
                got.an_write = rsp_ch.an_write;
                got.indirect_pending = rsp_ch.indirect_pending;
                got.words_used = rsp_ch.words_used;
                got.illegal = rsp_ch.illegal;
                if (address_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: address %h", $time,
                             got.address);
                    n_errors++;
                end
                else
                begin
                    exp_r = address_q.pop_front();
                    n_checked++;
                    n_illegal += exp_r.illegal;
                    n_pointer += exp_r.indirect_pending;
                    n_update += exp_r.an_write;
                    if (got.address !== exp_r.address)
                        note_mismatch("address", exp_r.address, got.address);
                    if (got.an_new !== exp_r.an_new)
                        note_mismatch("an_new", exp_r.an_new, got.an_new);
                    if (got.an_write !== exp_r.an_write)
                        note_mismatch("an_write", 32'(exp_r.an_write), 32'(got.an_write));
                    if (got.indirect_pending !== exp_r.indirect_pending)
                        note_mismatch("indirect_pending", 32'(exp_r.indirect_pending),
                                      32'(got.indirect_pending));
                    if (got.words_used !== exp_r.words_used)
                        note_mismatch("words_used", 32'(exp_r.words_used),
                                      32'(got.words_used));
                    if (got.illegal !== exp_r.illegal)
                        note_mismatch("illegal", 32'(exp_r.illegal), 32'(got.illegal));
                end
            end
            if (hold_off)
                rsp_rdy <= 1'b0;
            else if (rsp_stall != 0)
            begin
                rsp_rdy <= 1'b0;
                rsp_stall <= rsp_stall - 1;
            end
            else
            begin
                rsp_rdy <= 1'b1;
                rsp_stall <= pick_gap();
            end
        end
    end

    // Hold off the result side for a long stretch so the unit backs up
    initial
    begin
        while (n_accepted < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (150)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     address_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        ea_req_t r;
        int      n_random;
        n_random = 0;

        // Directed: stray pointer data, register modes, step and wrap cases
        request_q.push_back(pointer_data());
        request_q.push_back(addr_req(MODE_DN_DIRECT, 3'd0, SIZE_WORD, 1'b0, 32'h0, 16'h0));
        request_q.push_back(addr_req(MODE_AN_DIRECT, 3'd5, SIZE_WORD, 1'b0, 32'h0, 16'h0));
        request_q.push_back(addr_req(MODE_AN_IND, 3'd2, 3'd0, 1'b1, 32'hffff_ffff, 16'h0));
        request_q.push_back(addr_req(MODE_AN_POST, 3'd1, 3'd4, 1'b0, 32'hffff_fffe, 16'h0));
        request_q.push_back(addr_req(MODE_AN_POST, REG_SP, SIZE_BYTE, 1'b0, 32'h1000, 16'h0));
        request_q.push_back(addr_req(MODE_AN_POST, 3'd3, 3'd0, 1'b0, 32'h1000, 16'h0));
        request_q.push_back(addr_req(MODE_AN_PRE, 3'd3, SIZE_BYTE, 1'b1, 32'h0, 16'h0));
        request_q.push_back(addr_req(MODE_AN_PRE, REG_SP, 3'd7, 1'b0, 32'h0000_0004, 16'h0));
        request_q.push_back(addr_req(MODE_AN_DISP, 3'd4, 3'd0, 1'b0, 32'h0000_0010, 16'h8000));
        // Brief formats: long index scaled by 8, word index scaled by 4
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd0, 3'd0, 1'b0, 32'h0, 16'h8e80));
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd6, 3'd0, 1'b0, 32'hffff_fff0, 16'h047f));
        // Full format reserved encodings
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd0, 3'd0, 1'b0, 32'h0, 16'h0138));
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd0, 3'd0, 1'b0, 32'h0, 16'h0100));
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd0, 3'd0, 1'b0, 32'h0, 16'h0114));
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd0, 3'd0, 1'b0, 32'h0, 16'h0156));
        // Full format: base suppress with long displacement, no indirection
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd1, 3'd0, 1'b0, 32'h1234, 16'h0fb0));
        // Pre-indexed and post-indexed indirection, each completed by pointer data
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd2, 3'd0, 1'b0, 32'h8000_0000, 16'h0323));
        request_q.push_back(pointer_data());
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd2, 3'd0, 1'b0, 32'h4000, 16'h0916));
        request_q.push_back(pointer_data());
        // New request drops an open indirection; the late data is then illegal
        request_q.push_back(addr_req(MODE_AN_INDEX, 3'd2, 3'd0, 1'b0, 32'h4000, 16'h0111));
        request_q.push_back(addr_req(MODE_AN_IND, 3'd2, 3'd0, 1'b0, 32'h4000, 16'h0));
        request_q.push_back(pointer_data());
        // Special modes: absolute, PC-relative read and write, immediate and reserved
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_ABS_SHORT, 3'd0, 1'b0, 32'h0, 16'hffff));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_ABS_LONG, 3'd0, 1'b1, 32'h0, 16'h8001));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_PC_DISP, 3'd0, 1'b0, 32'h0, 16'h7fff));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_PC_DISP, 3'd0, 1'b1, 32'h0, 16'h0));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_PC_INDEX, 3'd0, 1'b1, 32'h0, 16'h0173));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_PC_INDEX, 3'd0, 1'b0, 32'h0, 16'h0173));
        request_q.push_back(pointer_data());
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_IMMEDIATE, 3'd0, 1'b0, 32'h0, 16'h0));
        request_q.push_back(addr_req(MODE_SPECIAL, SPC_RESERVED, 3'd0, 1'b0, 32'h0, 16'h0));

        // Random: mostly address requests, with pointer data following indirect ones
        while (n_random < RANDOM_ITEMS)
        begin
            r = random_request();
            request_q.push_back(r);
            n_random++;
            if (opens_pointer(r) && $urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    request_q.push_back(random_request());
                    n_random++;
                end
                request_q.push_back(pointer_data());
                n_random++;
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                request_q.push_back(pointer_data());
                n_random++;
            end
        end

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests in, all results back, then settle
        while (request_q.size() != 0 || req_vld)
            @(posedge clk);
        while (address_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d requests and %0d checked results", n_accepted, n_checked);
        $display("  %0d pointer fetches, %0d An write-backs, %0d illegal encodings, %0d errors",
                 n_pointer, n_update, n_illegal, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/m68kea_pkg.sv
rtl/m68kea_req_if.sv
rtl/m68kea_rsp_if.sv
rtl/m68kea_calc.sv
rtl/m68k_effective_address_unit.sv
tb/testbench.sv
